// ===== sv/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/bca_pkg.sv =====
// types, constants and codes of the block chain allocator
`timescale 1ns / 1ps
`default_nettype none

package bca_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int LINK_W     = BLK_W + 1;
  localparam int CNT_W      = BLK_W + 1;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;

  // bit BLK_W set marks the end of a chain
  localparam logic [LINK_W-1:0] END_LINK   = {1'b1, {BLK_W{1'b0}}};
  localparam logic [CNT_W-1:0]  NUM_BLK_C  = CNT_W'(NUM_BLOCKS);
  localparam logic [BLK_W-1:0]  LINK_LAST  = BLK_W'(NUM_BLOCKS - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd1;

  typedef enum logic [2:0] {
    OP_FORMAT  = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_APPEND  = 3'd2,
    OP_RELEASE = 3'd3,
    OP_WALK    = 3'd4,
    OP_COUNT   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_BAD_ARG  = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FMT,
    S_POP,
    S_TAIL_RD,
    S_TAIL,
    S_WALK,
    S_CNT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [BLK_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
    logic [BLK_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic [BLK_W-1:0] block;
    logic [CNT_W-1:0] count;
    stat_t            status;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/bca_link_ram.sv =====
// link table memory, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none

module bca_link_ram import bca_pkg::*; (
  input  wire logic              clk,
  input  wire ram_req_t          req,
  output      logic [LINK_W-1:0] rdata
);

  logic [LINK_W-1:0] mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

// ===== sv/bca_seq.sv =====
// operation sequencer: one table access per cycle, chain walks one link a cycle
`timescale 1ns / 1ps
`default_nettype none

module bca_seq import bca_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [2:0]        in_op,
  input  wire logic [BLK_W-1:0]  in_start_block,
  input  wire logic [BLK_W-1:0]  in_chain_index,
  input  wire logic [CNT_W-1:0]  total,
  input  wire logic [BLK_W-1:0]  reserved,
  output      ram_req_t          ram_req,
  input  wire logic [LINK_W-1:0] ram_rdata,
  output      logic              res_valid,
  output      res_t              res,
  input  wire logic              res_ready
);

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [BLK_W-1:0]  start_r, start_nxt;
  logic [BLK_W-1:0]  index_r, index_nxt;
  logic [LINK_W-1:0] free_head_r, free_head_nxt;
  logic [BLK_W-1:0]  cur_r, cur_nxt;
  logic [BLK_W-1:0]  n_r, n_nxt;
  logic [LINK_W-1:0] link_val_r, link_val_nxt;
  logic [BLK_W-1:0]  res_block_r, res_block_nxt;
  logic [CNT_W-1:0]  res_count_r, res_count_nxt;
  stat_t             res_status_r, res_status_nxt;

  logic             accept;
  logic             start_ok;
  logic             head_end;
  logic             rd_end;
  logic [BLK_W-1:0] rd_blk;
  logic             fmt_ok;
  logic             fmt_last;
  logic [CNT_W-1:0] fmt_succ;
  logic             walk_hit;
  logic             tail_max;
  logic             cnt_full;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign start_ok = CNT_W'(start_r) < total;
  assign head_end = free_head_r[BLK_W];
  assign rd_end   = ram_rdata[BLK_W];
  assign rd_blk   = ram_rdata[BLK_W-1:0];
  assign fmt_ok   = CNT_W'(reserved) < total;
  assign fmt_succ = CNT_W'(cur_r) + CNT_W'(1);
  assign fmt_last = fmt_succ == total;
  assign walk_hit = (CNT_W'(n_r) + CNT_W'(1)) == CNT_W'(index_r);
  assign tail_max = n_r == LINK_LAST;
  assign cnt_full = res_count_r == NUM_BLK_C;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_FORMAT: begin
            if (fmt_ok) state_nxt = S_FMT;
          end
          OP_ALLOC: begin
            if (!head_end) state_nxt = S_POP;
          end
          OP_APPEND: begin
            if (start_ok && !head_end) state_nxt = S_POP;
          end
          OP_RELEASE: begin
            if (start_ok) state_nxt = S_TAIL_RD;
          end
          OP_WALK: begin
            if (start_ok && (index_r != '0)) state_nxt = S_WALK;
          end
          OP_COUNT: begin
            if (!head_end) state_nxt = S_CNT;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FMT: begin
        if (fmt_last) state_nxt = S_DONE;
      end
      S_POP: begin
        state_nxt = (op_r == OP_APPEND) ? S_TAIL_RD : S_DONE;
      end
      S_TAIL_RD: state_nxt = S_TAIL;
      S_TAIL: begin
        if (rd_end || tail_max) state_nxt = S_DONE;
      end
      S_WALK: begin
        if (rd_end || walk_hit) state_nxt = S_DONE;
      end
      S_CNT: begin
        if (rd_end || cnt_full) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and table requests
  always_comb begin
    op_nxt         = op_r;
    start_nxt      = start_r;
    index_nxt      = index_r;
    free_head_nxt  = free_head_r;
    cur_nxt        = cur_r;
    n_nxt          = n_r;
    link_val_nxt   = link_val_r;
    res_block_nxt  = res_block_r;
    res_count_nxt  = res_count_r;
    res_status_nxt = res_status_r;
    ram_req        = '{we: 1'b0, waddr: cur_r, wdata: link_val_r, raddr: cur_r};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = op_t'(in_op);
          start_nxt      = in_start_block;
          index_nxt      = in_chain_index;
          res_block_nxt  = '0;
          res_count_nxt  = '0;
          res_status_nxt = STAT_OK;
        end
      end
      S_DISPATCH: begin
        case (op_r)
          OP_FORMAT: begin
            if (fmt_ok) begin
              free_head_nxt = {1'b0, reserved};
              cur_nxt       = reserved;
            end else begin
              free_head_nxt = END_LINK;
            end
          end
          OP_ALLOC, OP_APPEND: begin
            if ((op_r == OP_APPEND) && !start_ok) begin
              res_status_nxt = STAT_BAD_ARG;
            end else if (head_end) begin
              res_status_nxt = STAT_NO_SPACE;
            end else begin
              ram_req.raddr = free_head_r[BLK_W-1:0];
            end
          end
          OP_RELEASE: begin
            if (!start_ok) begin
              res_status_nxt = STAT_BAD_ARG;
            end else begin
              // old free list hangs behind the released chain
              link_val_nxt  = free_head_r;
              free_head_nxt = {1'b0, start_r};
              cur_nxt       = start_r;
              n_nxt         = '0;
            end
          end
          OP_WALK: begin
            if (!start_ok) begin
              res_status_nxt = STAT_BAD_ARG;
            end else if (index_r == '0) begin
              res_block_nxt = start_r;
            end else begin
              ram_req.raddr = start_r;
              n_nxt         = '0;
            end
          end
          OP_COUNT: begin
            if (!head_end) begin
              res_count_nxt = CNT_W'(1);
              ram_req.raddr = free_head_r[BLK_W-1:0];
            end
          end
          default: res_status_nxt = STAT_BAD_ARG;
        endcase
      end
      S_FMT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cur_r;
        ram_req.wdata = fmt_last ? END_LINK : fmt_succ;
        if (!fmt_last) cur_nxt = fmt_succ[BLK_W-1:0];
      end
      S_POP: begin
        // popped block becomes a chain end
        free_head_nxt = ram_rdata;
        ram_req.we    = 1'b1;
        ram_req.waddr = free_head_r[BLK_W-1:0];
        ram_req.wdata = END_LINK;
        res_block_nxt = free_head_r[BLK_W-1:0];
        link_val_nxt  = free_head_r;
        cur_nxt       = start_r;
        n_nxt         = '0;
      end
      S_TAIL_RD: begin
        ram_req.raddr = cur_r;
      end
      S_TAIL: begin
        if (rd_end) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = cur_r;
        end else if (tail_max) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = rd_blk;
        end else begin
          cur_nxt       = rd_blk;
          n_nxt         = n_r + BLK_W'(1);
          ram_req.raddr = rd_blk;
        end
      end
      S_WALK: begin
        if (rd_end) begin
          res_status_nxt = STAT_BAD_ARG;
        end else if (walk_hit) begin
          res_block_nxt = rd_blk;
        end else begin
          n_nxt         = n_r + BLK_W'(1);
          ram_req.raddr = rd_blk;
        end
      end
      S_CNT: begin
        if (!rd_end && !cnt_full) begin
          res_count_nxt = res_count_r + CNT_W'(1);
          ram_req.raddr = rd_blk;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= END_LINK;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
    end
    op_r         <= op_nxt;
    start_r      <= start_nxt;
    index_r      <= index_nxt;
    cur_r        <= cur_nxt;
    n_r          <= n_nxt;
    link_val_r   <= link_val_nxt;
    res_block_r  <= res_block_nxt;
    res_count_r  <= res_count_nxt;
    res_status_r <= res_status_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign res_valid = state_r == S_DONE;
  assign res       = '{block: res_block_r, count: res_count_r, status: res_status_r};

endmodule

`default_nettype wire

// ===== sv/block_chain_allocator.sv =====
// top level of the block chain allocator: config registers, sequencer, table, output register
`timescale 1ns / 1ps
`default_nettype none

// Block chain allocator. A 1024-entry link table, one next-block entry per block,
// and a free-list head. Each item carries one operation: format, allocate, append,
// release, walk or count free, and yields exactly one result item. Items are taken
// one at a time; in_stall stays high from the cycle after acceptance until the
// result has moved into the output register. The link table has one write and one
// registered read port, and every chain walk goes through it one link per cycle,
// so the cost of format grows with total - reserved, of append and release with
// the blocks in the chain, of walk with chain_index and of count with the
// free-list length; allocate and rejected or trivial operations walk no chain.
// A result waiting in the output register does not hold up the next item until
// the sequencer has another one to hand over. Format must be issued before any
// other operation; table entries are not cleared by reset. Configuration must be
// written only while the block is idle; the block does not enforce this itself.
module block_chain_allocator import bca_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  // input channel
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [2:0]           in_op,
  input  wire logic [BLK_W-1:0]     in_start_block,
  input  wire logic [BLK_W-1:0]     in_chain_index,
  // result channel
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [BLK_W-1:0]     out_result_block,
  output      logic [CNT_W-1:0]     out_free_count,
  output      logic [1:0]           out_status
);

  logic [CFG_W-1:0] total_r;
  logic [BLK_W-1:0] reserved_r;
  logic [CNT_W-1:0] total_use;

  ram_req_t          ram_req;
  logic [LINK_W-1:0] ram_rdata;

  logic res_valid;
  logic res_ready;
  res_t res;

  logic             out_valid_r;
  logic [BLK_W-1:0] out_block_r;
  logic [CNT_W-1:0] out_count_r;
  logic [1:0]       out_status_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= CFG_W'(1024);
      reserved_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOTAL:    total_r    <= cfg_wdata;
        CFG_RESERVED: reserved_r <= cfg_wdata[BLK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // device size clipped to the table depth
  assign total_use = (CNT_W'(total_r) > NUM_BLK_C) ? NUM_BLK_C : CNT_W'(total_r);

  bca_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_start_block (in_start_block),
    .in_chain_index (in_chain_index),
    .total          (total_use),
    .reserved       (reserved_r),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready)
  );

  bca_link_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // output register: refilled as soon as the waiting item leaves
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_block_r  <= res.block;
      out_count_r  <= res.count;
      out_status_r <= res.status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_block = out_block_r;
  assign out_free_count   = out_count_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

// ===== sv/bca_checker.sv =====
// port-level checks of the block chain allocator and their binding
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bca_checker import bca_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [BLK_W-1:0] out_result_block,
  input wire logic [CNT_W-1:0] out_free_count,
  input wire logic [1:0]       out_status
);

  // an accepted item keeps the block busy in the next cycle
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall, "not busy after accept")

  // a stalled result stays offered
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // no-space results carry no block and no count
  `ASSERT_CLK(a_nospace_clean, clk, rst_n, out_valid && (out_status == STAT_NO_SPACE) |-> (out_result_block == '0) && (out_free_count == '0), "no-space result not clean")

  // leaving reset the block is idle with nothing to deliver
  `ASSERT_CLK_NR(a_reset_idle, clk, rst_n && !$past(rst_n) |-> !out_valid && !in_stall, "not idle after reset")

endmodule

bind block_chain_allocator bca_checker u_chk (.*);

`default_nettype wire

// ===== tb/sv/tb_block_chain_allocator.sv =====
// self-checking testbench for the block chain allocator, with its own model of the link table
`timescale 1ns / 1ps

module tb_block_chain_allocator;
  import bca_pkg::*;

  // codes with no package name: the two undefined ops and a config index with no register
  localparam logic [2:0]           OP_UNDEF_LO = 3'd6;
  localparam logic [2:0]           OP_UNDEF_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
  localparam logic [CNT_W-1:0]     CNT_MAX     = {CNT_W{1'b1}};
  localparam int                   HOLD_CYCLES = 300;
  localparam int                   SETTLE      = 40;

  typedef struct packed {
    logic [BLK_W-1:0] block;
    logic [CNT_W-1:0] count;
    stat_t            status;
  } alloc_res_t;

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_W-1:0]     cfg_wdata      = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [2:0]           in_op          = '0;
  logic [BLK_W-1:0]     in_start_block = '0;
  logic [BLK_W-1:0]     in_chain_index = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic [BLK_W-1:0]     out_result_block;
  logic [CNT_W-1:0]     out_free_count;
  logic [1:0]           out_status;

  block_chain_allocator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_start_block   (in_start_block),
    .in_chain_index   (in_chain_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block),
    .out_free_count   (out_free_count),
    .out_status       (out_status)
  );

  // shadow of the allocator: link table, which entries hold a value, free-list head, registers
  logic [LINK_W-1:0] link_mem [NUM_BLOCKS];
  bit                link_set [NUM_BLOCKS];
  logic [LINK_W-1:0] head_blk     = END_LINK;
  logic [CFG_W-1:0]  dev_total    = CFG_W'(NUM_BLOCKS);
  logic [BLK_W-1:0]  dev_reserved = '0;
  bit                read_unwritten;

  alloc_res_t expected_results [$];
  alloc_res_t last_result;
  alloc_res_t want;
  bit         item_taken;
  int         errors        = 0;
  int         hold_requests = 0;
  bit         tx_calm       = 1'b0;
  int         tx_calm_left  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short idle runs, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 6) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // any read of an entry never written flags the item, so it is withdrawn before it is sent
  function automatic logic [LINK_W-1:0] read_link(input logic [LINK_W-1:0] blk);
    if (!link_set[blk[BLK_W-1:0]]) read_unwritten = 1'b1;
    return link_mem[blk[BLK_W-1:0]];
  endfunction

  function automatic void write_link(input logic [LINK_W-1:0] blk, input logic [LINK_W-1:0] nxt);
    link_mem[blk[BLK_W-1:0]] = nxt;
    link_set[blk[BLK_W-1:0]] = 1'b1;
  endfunction

  // last block of a chain; a looping chain gives up after NUM_BLOCKS links
  function automatic logic [LINK_W-1:0] chain_tail(input logic [LINK_W-1:0] first);
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] nxt;
    cur = first;
    for (int n = 0; n < NUM_BLOCKS; n++) begin
      nxt = read_link(cur);
      if (nxt[BLK_W]) break;
      cur = nxt;
    end
    return cur;
  endfunction

  // applies one operation to the shadow state and returns the result item it gives
  function automatic alloc_res_t apply_op(input logic [2:0] op, input logic [BLK_W-1:0] start,
                                          input logic [BLK_W-1:0] idx);
    alloc_res_t        res;
    int unsigned       in_use;
    int unsigned       cnt;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] blk;
    res            = '{block: '0, count: '0, status: STAT_OK};
    read_unwritten = 1'b0;
    in_use         = (dev_total < NUM_BLOCKS) ? dev_total : NUM_BLOCKS;
    case (op)
      OP_FORMAT: begin
        if (dev_reserved < in_use) begin
          head_blk = LINK_W'(dev_reserved);
          for (int unsigned b = dev_reserved; b + 1 < in_use; b++)
            write_link(LINK_W'(b), LINK_W'(b + 1));
          write_link(LINK_W'(in_use - 1), END_LINK);
        end else begin
          head_blk = END_LINK;
        end
      end
      OP_ALLOC, OP_APPEND: begin
        if (op == OP_APPEND && start >= in_use) begin
          res.status = STAT_BAD_ARG;
        end else if (head_blk[BLK_W]) begin
          res.status = STAT_NO_SPACE;
        end else begin
          blk      = head_blk;
          head_blk = read_link(blk);
          write_link(blk, END_LINK);
          res.block = blk[BLK_W-1:0];
          if (op == OP_APPEND) write_link(chain_tail(LINK_W'(start)), blk);
        end
      end
      OP_RELEASE: begin
        if (start >= in_use) begin
          res.status = STAT_BAD_ARG;
        end else begin
          // old free list hangs behind the released chain
          cur      = head_blk;
          head_blk = LINK_W'(start);
          write_link(chain_tail(LINK_W'(start)), cur);
        end
      end
      OP_WALK: begin
        if (start >= in_use) begin
          res.status = STAT_BAD_ARG;
        end else begin
          cur = LINK_W'(start);
          for (int unsigned n = 0; n < idx; n++) begin
            cur = read_link(cur);
            if (cur[BLK_W]) break;
          end
          if (cur[BLK_W]) res.status = STAT_BAD_ARG;
          else res.block = cur[BLK_W-1:0];
        end
      end
      OP_COUNT: begin
        cnt = 0;
        cur = head_blk;
        for (int n = 0; n < NUM_BLOCKS && !cur[BLK_W]; n++) begin
          cnt++;
          cur = read_link(cur);
        end
        res.count = (cnt > CNT_MAX) ? CNT_MAX : CNT_W'(cnt);
      end
      default: res.status = STAT_BAD_ARG;
    endcase
    return res;
  endfunction

  // predicts one item and offers it; an item that would read an unwritten entry is dropped
  task automatic send_item(input logic [2:0] op, input logic [BLK_W-1:0] start,
                           input logic [BLK_W-1:0] idx);
    logic [LINK_W-1:0] mem_keep [NUM_BLOCKS];
    bit                set_keep [NUM_BLOCKS];
    logic [LINK_W-1:0] head_keep;
    int unsigned       gap;
    mem_keep    = link_mem;
    set_keep    = link_set;
    head_keep   = head_blk;
    last_result = apply_op(op, start, idx);
    item_taken  = !read_unwritten;
    if (read_unwritten) begin
      link_mem = mem_keep;
      link_set = set_keep;
      head_blk = head_keep;
      return;
    end
    expected_results.push_back(last_result);
    // sender alternates between calm stretches and gappy ones
    if (tx_calm_left == 0) begin
      tx_calm      = ($urandom_range(0, 3) == 0);
      tx_calm_left = $urandom_range(20, 120);
    end
    tx_calm_left--;
    gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_start_block <= start;
    in_chain_index <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  // sender goes quiet until every predicted result item has come back
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_TOTAL) dev_total = data;
    else if (idx == CFG_RESERVED) dev_reserved = data[BLK_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: long hold on request, otherwise calm stretches and random stall runs
  initial begin
    int hold_left;
    int hold_served;
    int run_left;
    int calm_left;
    bit calm;
    bit stall;
    hold_left   = 0;
    hold_served = 0;
    run_left    = 0;
    calm_left   = 0;
    calm        = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else begin
        if (calm_left == 0) begin
          calm      = ($urandom_range(0, 3) == 0);
          calm_left = $urandom_range(50, 300);
        end
        calm_left--;
        if (calm) begin
          stall = 1'b0;
        end else if (run_left > 0) begin
          run_left--;
          stall = 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
          run_left = idle_len() - 1;
          stall    = 1'b1;
        end else begin
          stall = 1'b0;
        end
      end
      out_stall <= stall;
    end
  end

  // every result item taken is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: block %0d count %0d status %0d",
               out_result_block, out_free_count, out_status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_result_block !== want.block) begin
          $error("result_block: expected %0d, got %0d", want.block, out_result_block);
          errors++;
        end
        if (out_free_count !== want.count) begin
          $error("free_count: expected %0d, got %0d", want.count, out_free_count);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
      end
    end
  end

  // before any format: only ops that read nothing, plus both undefined ops
  task automatic test_unformatted();
    send_item(OP_COUNT, '0, '0);
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_APPEND, LINK_LAST, LINK_LAST);
    send_item(OP_UNDEF_LO, '0, '0);
    send_item(OP_UNDEF_HI, LINK_LAST, LINK_LAST);
  endtask

  // full device at reset settings: build a chain, walk it to and past its end, give it back
  task automatic test_chain_ops();
    send_item(OP_FORMAT, '0, '0);
    send_item(OP_COUNT, '0, '0);
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_APPEND, '0, '0);
    send_item(OP_WALK, '0, '0);
    send_item(OP_WALK, '0, 10'd1);
    send_item(OP_WALK, '0, LINK_LAST);
    send_item(OP_RELEASE, '0, '0);
    send_item(OP_COUNT, '0, '0);
  endtask

  // tiny device: starts beyond the device, a self-looping free list, running out of blocks
  task automatic test_small_device();
    wait_drain();
    write_cfg(CFG_TOTAL, CFG_W'(5));
    write_cfg(CFG_RESERVED, CFG_W'(3));
    send_item(OP_FORMAT, '0, '0);
    send_item(OP_WALK, 10'd5, '0);
    send_item(OP_RELEASE, LINK_LAST, '0);
    send_item(OP_ALLOC, '0, '0);
    // releasing the lone free block onto itself closes a loop; count must stop at the cap
    send_item(OP_RELEASE, 10'd4, '0);
    send_item(OP_COUNT, '0, '0);
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_FORMAT, '0, '0);
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_ALLOC, '0, '0);
  endtask

  // receiver holds off while the sender keeps offering, so the block fills and stalls its input
  task automatic test_backpressure();
    wait_drain();
    send_item(OP_FORMAT, '0, '0);
    tx_calm      = 1'b1;
    tx_calm_left = 40;
    hold_requests++;
    repeat (16)
      send_item(3'($urandom_range(1, 5)), 10'($urandom_range(3, 4)), 10'($urandom_range(0, 2)));
    wait_drain();
  endtask

  // random phases over several device shapes, extremes among them
  task automatic test_random_phases();
    int unsigned   ph_total    [10] = '{16, 1024, 1, 2047, 0, 40, 64, 5, 1024, 200};
    int unsigned   ph_reserved [10] = '{2, 0, 0, 1020, 0, 39, 8, 9, 1023, 3};
    int unsigned   ph_items    [10] = '{250, 60, 30, 80, 15, 30, 250, 20, 30, 250};
    logic [BLK_W-1:0] chain_heads [$];
    logic [2:0]       op;
    logic [BLK_W-1:0] start;
    logic [BLK_W-1:0] idx;
    int unsigned      n;
    int unsigned      pick;
    int               slot;
    for (int p = 0; p < 10; p++) begin
      wait_drain();
      write_cfg(CFG_TOTAL, CFG_W'(ph_total[p]));
      // top bit of the reserved write is not part of the register
      write_cfg(CFG_RESERVED, {1'($urandom_range(0, 1)), BLK_W'(ph_reserved[p])});
      if (p % 3 == 0) write_cfg(CFG_SPARE, CFG_W'($urandom_range(0, 2047)));
      send_item(OP_FORMAT, '0, '0);
      chain_heads.delete();
      n = 0;
      while (n < ph_items[p]) begin
        pick  = $urandom_range(0, 99);
        op    = OP_COUNT;
        start = '0;
        idx   = '0;
        slot  = -1;
        if (chain_heads.size() == 0 && pick >= 25 && pick < 80) pick = 0;
        if (pick < 25) begin
          op = OP_ALLOC;
        end else if (pick < 80) begin
          // well-formed use of a chain that was handed out
          slot  = $urandom_range(0, chain_heads.size() - 1);
          start = chain_heads[slot];
          if (pick < 50) begin
            op = OP_APPEND;
          end else if (pick < 70) begin
            op  = OP_WALK;
            idx = BLK_W'($urandom_range(0, 5));
          end else begin
            op = OP_RELEASE;
          end
        end else if (pick >= 88) begin
          // noise: any op, any start, any index
          op    = 3'($urandom_range(0, 7));
          start = BLK_W'($urandom_range(0, 1023));
          idx   = BLK_W'($urandom_range(0, 1023));
        end
        send_item(op, start, idx);
        if (item_taken) begin
          n++;
          if (op == OP_FORMAT)
            chain_heads.delete();
          else if (op == OP_ALLOC && last_result.status == STAT_OK)
            chain_heads.push_back(last_result.block);
          else if (op == OP_RELEASE && slot >= 0 && last_result.status == STAT_OK)
            chain_heads.delete(slot);
        end
      end
    end
  endtask

  initial begin
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      link_mem[b] = '0;
      link_set[b] = 1'b0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_unformatted();
    test_chain_ops();
    test_small_device();
    test_backpressure();
    test_random_phases();
    wait_drain();
    // late or extra result items would show up here
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #(60_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
